/* src/ascii_hex_frame_receiver_lrc_top_assert.svh */
// Assertion macros used by the receiver core (ahfr_core).
`ifndef ASCII_HEX_FRAME_RECEIVER_LRC_TOP_ASSERT_SVH
`define ASCII_HEX_FRAME_RECEIVER_LRC_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked at every rising clock edge outside reset
`define AHFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahfr assertion failed");

// implication whose consequent is checked on the next clock edge
`define AHFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahfr assertion failed");

`else

`define AHFR_ASSERT_IMPL(lbl, ante, cons)
`define AHFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/ahfr_pkg.sv */
package ahfr_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_CR    = 2'd2
    } rx_mode_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_LRC    = 2'd2;
    localparam logic [1:0] ST_ABORT  = 2'd3;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    localparam int CHAR_CNT_W = 8;
    localparam int BYTE_CNT_W = 7;

    typedef struct packed {
        logic                  is_frame_end;
        logic [7:0]            data_byte;
        logic [1:0]            frame_status;
        logic [BYTE_CNT_W-1:0] frame_length;
    } result_t;

    // {is_hex, nibble}; non-hex characters decode as nibble 0
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            hex_decode = 5'h00;
            if (c inside {[8'h30:8'h39]}) begin
                d = c - CH_0;
                hex_decode = {1'b1, d[3:0]};
            end
            else if (c inside {[8'h41:8'h46]}) begin
                d = c - CH_UA + 8'd10;
                hex_decode = {1'b1, d[3:0]};
            end
            else if (c inside {[8'h61:8'h66]}) begin
                d = c - CH_LA + 8'd10;
                hex_decode = {1'b1, d[3:0]};
            end
        end
    endfunction

endpackage

/* src/ascii_hex_frame_receiver_lrc_top.sv */
// Receive side of an ASCII hex framed link with LRC check.
// Slave channel s_*: one received character per transaction in s_tdata.
// Master channel m_*: one result per transaction. m_tlast low carries a
// decoded data byte; m_tlast high carries the frame-end status and the count
// of data bytes sent for that frame. Data bytes go out one pair late, so the
// trailing LRC byte never appears; discard the frame when status is nonzero
// (1 format, 2 LRC mismatch, 3 aborted).
// Timing: a character passes an input register and a result register. Its
// result is loaded into the result register when that register is free, and
// m_tvalid is driven from the result register. Characters that give no result
// simply vanish. One character per cycle is taken sustained while m_tready
// stays high; the decode and the next frame state are computed combinationally
// between the two registers.
// Reset (rst_n low, async) empties both registers and returns the receiver
// to idle, waiting for a colon.
// When m_tready is low the result register holds its item, the input register
// fills, and s_tready drops until the result is taken.
module ascii_hex_frame_receiver_lrc_top #(
    parameter int MAX_FRAME_CHARS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                   // [16:10] frame_length, [23:17] zero
    output logic        m_tlast    // is_frame_end
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              out_free;
    logic              step;
    logic              res_valid;
    ahfr_pkg::result_t res;
    ahfr_pkg::result_t out_res;

    assign step = in_valid && out_free;

    ahfr_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (out_free),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    ahfr_core #(
        .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    ahfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_res   (out_res)
    );

    assign m_tlast = out_res.is_frame_end;
    assign m_tdata = {7'b0, out_res.frame_length, out_res.frame_status, out_res.data_byte};

endmodule

/* src/ahfr_in_reg.sv */
module ahfr_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

/* src/ahfr_core.sv */
`include "ascii_hex_frame_receiver_lrc_top_assert.svh"

module ahfr_core #(
    parameter int MAX_FRAME_CHARS = 255
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output ahfr_pkg::result_t res
);

    localparam logic [ahfr_pkg::CHAR_CNT_W-1:0] MAX_CC =
        ahfr_pkg::CHAR_CNT_W'(MAX_FRAME_CHARS);

    ahfr_pkg::rx_mode_t                  mode_reg, mode_next;
    logic [ahfr_pkg::CHAR_CNT_W-1:0]     char_count_reg, char_count_next;
    logic                                nibble_phase_reg, nibble_phase_next;
    logic [3:0]                          high_nibble_reg, high_nibble_next;
    logic [7:0]                          held_byte_reg, held_byte_next;
    logic                                have_held_reg, have_held_next;
    logic [7:0]                          lrc_sum_reg, lrc_sum_next;
    logic                                bad_char_reg, bad_char_next;
    logic [ahfr_pkg::BYTE_CNT_W-1:0]     byte_count_reg, byte_count_next;

    logic [ahfr_pkg::CHAR_CNT_W-1:0] cc_inc;
    logic [4:0]                      hex;
    logic [7:0]                      pair_value;

    assign cc_inc     = char_count_reg + 1'b1;
    assign hex        = ahfr_pkg::hex_decode(rx_byte);
    assign pair_value = {high_nibble_reg, hex[3:0]};

    always_comb
    begin
        mode_next         = mode_reg;
        char_count_next   = char_count_reg;
        nibble_phase_next = nibble_phase_reg;
        high_nibble_next  = high_nibble_reg;
        held_byte_next    = held_byte_reg;
        have_held_next    = have_held_reg;
        lrc_sum_next      = lrc_sum_reg;
        bad_char_next     = bad_char_reg;
        byte_count_next   = byte_count_reg;
        res_valid         = 1'b0;
        res               = '0;

        // frame-end items report the count before any reopen
        res.frame_length  = '0;

        case (mode_reg)
            ahfr_pkg::MODE_IDLE:
            begin
                if (rx_byte == ahfr_pkg::CH_COLON)
                begin
                    mode_next = ahfr_pkg::MODE_FRAME;
                end
            end
            ahfr_pkg::MODE_CR:
            begin
                res_valid          = 1'b1;
                res.is_frame_end   = 1'b1;
                res.frame_length   = byte_count_reg;
                if (rx_byte == ahfr_pkg::CH_COLON)
                begin
                    res.frame_status = ahfr_pkg::ST_ABORT;
                    mode_next        = ahfr_pkg::MODE_FRAME;
                end
                else
                begin
                    mode_next = ahfr_pkg::MODE_IDLE;
                    if (rx_byte != ahfr_pkg::CH_LF)
                        res.frame_status = ahfr_pkg::ST_ABORT;
                    else if (bad_char_reg || nibble_phase_reg || !have_held_reg)
                        res.frame_status = ahfr_pkg::ST_FORMAT;
                    else if (lrc_sum_reg != 8'h00)
                        res.frame_status = ahfr_pkg::ST_LRC;
                    else
                        res.frame_status = ahfr_pkg::ST_OK;
                end
            end
            ahfr_pkg::MODE_FRAME:
            begin
                if (rx_byte == ahfr_pkg::CH_COLON)
                begin
                    res_valid        = 1'b1;
                    res.is_frame_end = 1'b1;
                    res.frame_status = ahfr_pkg::ST_ABORT;
                    res.frame_length = byte_count_reg;
                end
                else
                begin
                    char_count_next = cc_inc;
                    if (rx_byte == ahfr_pkg::CH_CR)
                    begin
                        if (cc_inc >= MAX_CC)
                        begin
                            mode_next        = ahfr_pkg::MODE_IDLE;
                            res_valid        = 1'b1;
                            res.is_frame_end = 1'b1;
                            res.frame_status = ahfr_pkg::ST_ABORT;
                            res.frame_length = byte_count_reg;
                        end
                        else
                        begin
                            mode_next = ahfr_pkg::MODE_CR;
                        end
                    end
                    else
                    begin
                        if (!hex[4])
                            bad_char_next = 1'b1;
                        nibble_phase_next = !nibble_phase_reg;
                        if (!nibble_phase_reg)
                            high_nibble_next = hex[3:0];
                        if (cc_inc >= MAX_CC)
                        begin
                            // overflow drops any pair completed here
                            mode_next        = ahfr_pkg::MODE_IDLE;
                            res_valid        = 1'b1;
                            res.is_frame_end = 1'b1;
                            res.frame_status = ahfr_pkg::ST_ABORT;
                            res.frame_length = byte_count_reg;
                        end
                        else if (nibble_phase_reg)
                        begin
                            lrc_sum_next   = lrc_sum_reg + pair_value;
                            held_byte_next = pair_value;
                            have_held_next = 1'b1;
                            if (have_held_reg)
                            begin
                                res_valid       = 1'b1;
                                res.data_byte   = held_byte_reg;
                                byte_count_next = byte_count_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                mode_next = ahfr_pkg::MODE_IDLE;
            end
        endcase

        // a colon in idle, frame or CR mode resets the frame context
        if (rx_byte == ahfr_pkg::CH_COLON && mode_reg != ahfr_pkg::MODE_IDLE
            && mode_reg != ahfr_pkg::MODE_FRAME && mode_reg != ahfr_pkg::MODE_CR)
        begin
            mode_next = ahfr_pkg::MODE_IDLE;
        end
        else if (rx_byte == ahfr_pkg::CH_COLON)
        begin
            char_count_next   = ahfr_pkg::CHAR_CNT_W'(1);
            nibble_phase_next = 1'b0;
            high_nibble_next  = '0;
            held_byte_next    = '0;
            have_held_next    = 1'b0;
            lrc_sum_next      = '0;
            bad_char_next     = 1'b0;
            byte_count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ahfr_pkg::MODE_IDLE;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            nibble_phase_reg <= 1'b0;
            high_nibble_reg  <= '0;
            held_byte_reg    <= '0;
            have_held_reg    <= 1'b0;
            lrc_sum_reg      <= '0;
            bad_char_reg     <= 1'b0;
            byte_count_reg   <= '0;
        end
        else if (step)
        begin
            char_count_reg   <= char_count_next;
            nibble_phase_reg <= nibble_phase_next;
            high_nibble_reg  <= high_nibble_next;
            held_byte_reg    <= held_byte_next;
            have_held_reg    <= have_held_next;
            lrc_sum_reg      <= lrc_sum_next;
            bad_char_reg     <= bad_char_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    `AHFR_ASSERT_IMPL(a_data_needs_held, step && res_valid && !res.is_frame_end, have_held_reg)
    `AHFR_ASSERT_NEXT(a_end_leaves_cr, step && res_valid && res.is_frame_end,
        mode_reg != ahfr_pkg::MODE_CR)
    `AHFR_ASSERT_IMPL(a_data_fields_clear, res_valid && !res.is_frame_end,
        res.frame_status == ahfr_pkg::ST_OK && res.frame_length == '0)

endmodule

/* src/ahfr_out_reg.sv */
module ahfr_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              res_valid,
    input  ahfr_pkg::result_t res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ahfr_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    ahfr_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = res_valid;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign out_res  = res_reg;

endmodule

/* bench/ascii_hex_frame_receiver_lrc_top_tb.sv */
module ascii_hex_frame_receiver_lrc_top_tb;

    localparam int MAX_CHARS      = 255;
    localparam int RANDOM_CHARS   = 1250;
    localparam int TAIL_CHARS     = 200;
    localparam int HOLDOFF_AT     = 300;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LIMIT_TIME     = 1000000;

    typedef enum int {
        FLAW_NONE,
        FLAW_LRC,
        FLAW_BAD_CHAR,
        FLAW_ODD,
        FLAW_RESTART,
        FLAW_BAD_TERM,
        FLAW_NO_CR
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    logic [7:0]        char_queue [$];
    ahfr_pkg::result_t expected_results [$];
    int                mismatches = 0;
    int                chars_taken = 0;
    int                tail_start = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    logic              holdoff_used = 1'b0;

    // receiver model state
    ahfr_pkg::rx_mode_t rx_state = ahfr_pkg::MODE_IDLE;
    logic [7:0]         n_chars = 8'd0;
    logic               odd_nibble = 1'b0;
    logic [3:0]         hi_nib = 4'd0;
    logic [7:0]         held = 8'd0;
    logic               held_valid = 1'b0;
    logic [7:0]         sum = 8'd0;
    logic               saw_bad = 1'b0;
    logic [6:0]         n_bytes = 7'd0;

    ascii_hex_frame_receiver_lrc_top #(
        .MAX_FRAME_CHARS(MAX_CHARS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // -1 when not a hex digit
    function automatic int nibble_value(input logic [7:0] c);
        if (c >= ahfr_pkg::CH_0 && c < ahfr_pkg::CH_0 + 8'd10)
            return int'(c - ahfr_pkg::CH_0);
        if (c >= ahfr_pkg::CH_UA && c < ahfr_pkg::CH_UA + 8'd6)
            return int'(c - ahfr_pkg::CH_UA) + 10;
        if (c >= ahfr_pkg::CH_LA && c < ahfr_pkg::CH_LA + 8'd6)
            return int'(c - ahfr_pkg::CH_LA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return ahfr_pkg::CH_0 + 8'(n);
        if ($urandom_range(0, 1) == 0)
            return ahfr_pkg::CH_UA + 8'(n - 4'd10);
        return ahfr_pkg::CH_LA + 8'(n - 4'd10);
    endfunction

    task automatic open_frame_model();
        rx_state   = ahfr_pkg::MODE_FRAME;
        n_chars    = 8'd1;
        odd_nibble = 1'b0;
        hi_nib     = 4'd0;
        held       = 8'd0;
        held_valid = 1'b0;
        sum        = 8'd0;
        saw_bad    = 1'b0;
        n_bytes    = 7'd0;
    endtask

    task automatic push_frame_end(input logic [1:0] status);
        ahfr_pkg::result_t r;
        r.is_frame_end = 1'b1;
        r.data_byte    = 8'h00;
        r.frame_status = status;
        r.frame_length = n_bytes;
        expected_results.push_back(r);
    endtask

    task automatic predict_char(input logic [7:0] c);
        int                nib;
        logic [7:0]        value;
        logic              pair_done;
        ahfr_pkg::result_t r;
        pair_done = 1'b0;
        value = 8'h00;
        case (rx_state)
            ahfr_pkg::MODE_IDLE:
            begin
                if (c == ahfr_pkg::CH_COLON)
                    open_frame_model();
            end
            ahfr_pkg::MODE_CR:
            begin
                if (c == ahfr_pkg::CH_COLON)
                begin
                    push_frame_end(ahfr_pkg::ST_ABORT);
                    open_frame_model();
                end
                else
                begin
                    rx_state = ahfr_pkg::MODE_IDLE;
                    if (c != ahfr_pkg::CH_LF)
                        push_frame_end(ahfr_pkg::ST_ABORT);
                    else if (saw_bad || odd_nibble || !held_valid)
                        push_frame_end(ahfr_pkg::ST_FORMAT);
                    else if (sum != 8'd0)
                        push_frame_end(ahfr_pkg::ST_LRC);
                    else
                        push_frame_end(ahfr_pkg::ST_OK);
                end
            end
            ahfr_pkg::MODE_FRAME:
            begin
                if (c == ahfr_pkg::CH_COLON)
                begin
                    push_frame_end(ahfr_pkg::ST_ABORT);
                    open_frame_model();
                end
                else
                begin
                    n_chars = n_chars + 8'd1;
                    if (c == ahfr_pkg::CH_CR)
                    begin
                        if (n_chars >= MAX_CHARS)
                        begin
                            rx_state = ahfr_pkg::MODE_IDLE;
                            push_frame_end(ahfr_pkg::ST_ABORT);
                        end
                        else
                            rx_state = ahfr_pkg::MODE_CR;
                    end
                    else
                    begin
                        nib = nibble_value(c);
                        if (nib < 0)
                        begin
                            saw_bad = 1'b1;
                            nib = 0;
                        end
                        if (!odd_nibble)
                        begin
                            hi_nib = nib[3:0];
                            odd_nibble = 1'b1;
                        end
                        else
                        begin
                            odd_nibble = 1'b0;
                            value = {hi_nib, nib[3:0]};
                            pair_done = 1'b1;
                        end
                        // a pair completed by the overflowing character is lost
                        if (n_chars >= MAX_CHARS)
                        begin
                            rx_state = ahfr_pkg::MODE_IDLE;
                            push_frame_end(ahfr_pkg::ST_ABORT);
                        end
                        else if (pair_done)
                        begin
                            sum = sum + value;
                            if (held_valid)
                            begin
                                r.is_frame_end = 1'b0;
                                r.data_byte    = held;
                                r.frame_status = ahfr_pkg::ST_OK;
                                r.frame_length = '0;
                                expected_results.push_back(r);
                                n_bytes = n_bytes + 7'd1;
                            end
                            held = value;
                            held_valid = 1'b1;
                        end
                    end
                end
            end
            default:
                rx_state = ahfr_pkg::MODE_IDLE;
        endcase
    endtask

    task automatic queue_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            char_queue.push_back(s[i]);
    endtask

    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++)
            char_queue.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic queue_frame(input int n_data, input flaw_t flaw);
        logic [7:0] payload [$];
        logic [7:0] text [$];
        logic [7:0] lrc;
        logic [7:0] b;
        int         cut;
        lrc = 8'h00;
        for (int i = 0; i < n_data; i++)
        begin
            b = 8'($urandom_range(0, 255));
            lrc = lrc + b;
            payload.push_back(b);
        end
        lrc = 8'h00 - lrc;
        if (flaw == FLAW_LRC)
            lrc = lrc ^ (8'h01 << $urandom_range(0, 7));
        payload.push_back(lrc);
        foreach (payload[i])
        begin
            text.push_back(hex_char(payload[i][7:4]));
            text.push_back(hex_char(payload[i][3:0]));
        end
        if (flaw == FLAW_BAD_CHAR)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (nibble_value(b) >= 0 || b == ahfr_pkg::CH_COLON || b == ahfr_pkg::CH_CR);
            text[$urandom_range(0, text.size() - 1)] = b;
        end
        if (flaw == FLAW_ODD)
            text.delete($urandom_range(0, text.size() - 1));
        if (flaw == FLAW_RESTART)
        begin
            cut = $urandom_range(0, text.size());
            while (text.size() > cut)
                void'(text.pop_back());
        end
        char_queue.push_back(ahfr_pkg::CH_COLON);
        foreach (text[i])
            char_queue.push_back(text[i]);
        if (flaw == FLAW_RESTART || flaw == FLAW_NO_CR)
            return;
        char_queue.push_back(ahfr_pkg::CH_CR);
        if (flaw == FLAW_BAD_TERM)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == ahfr_pkg::CH_LF);
            char_queue.push_back(b);
        end
        else
            char_queue.push_back(ahfr_pkg::CH_LF);
    endtask

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    // sender: one pending character per transaction, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (chars_taken < tail_start && $urandom_range(0, 11) == 0)
            begin
                gap_left <= $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end
            else if (char_queue.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= char_queue.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stall bursts plus one long hold-off to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_left   <= 0;
            holdoff_used <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!holdoff_used && chars_taken >= HOLDOFF_AT)
        begin
            holdoff_used <= 1'b1;
            stall_left   <= HOLDOFF_CYCLES - 1;
            m_tready     <= 1'b0;
        end
        else if (chars_taken < tail_start && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        ahfr_pkg::result_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: tlast=%0b tdata=%h", m_tlast, m_tdata);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("is_frame_end", 8'(exp_r.is_frame_end), 8'(m_tlast));
                    check_field("data_byte", exp_r.data_byte, m_tdata[7:0]);
                    check_field("frame_status", 8'(exp_r.frame_status), 8'(m_tdata[9:8]));
                    check_field("frame_length", 8'(exp_r.frame_length),
                                8'(m_tdata[16:10]));
                    check_field("tdata_pad", 8'h00, 8'(m_tdata[23:17]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_char(s_tdata);
                chars_taken <= chars_taken + 1;
            end
        end
    end

    initial
    begin
        int    pick;
        int    base;
        flaw_t flaw;

        // directed: good lower-case frame, idle extremes, empty frame,
        // bad char within a pair, restart in frame, bad terminator
        queue_chars(":01ff");
        char_queue.push_back(ahfr_pkg::CH_CR);
        char_queue.push_back(ahfr_pkg::CH_LF);
        char_queue.push_back(8'h00);
        char_queue.push_back(8'hFF);
        queue_chars(":");
        char_queue.push_back(ahfr_pkg::CH_CR);
        char_queue.push_back(ahfr_pkg::CH_LF);
        queue_chars(":0G");
        char_queue.push_back(ahfr_pkg::CH_CR);
        char_queue.push_back(ahfr_pkg::CH_LF);
        queue_chars(":12:34");
        char_queue.push_back(ahfr_pkg::CH_CR);
        queue_chars("Q");

        base = char_queue.size();
        // one frame long enough to overflow
        queue_frame($urandom_range(126, 130), FLAW_NONE);
        while (char_queue.size() - base < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 86)
            begin
                if (pick < 55)
                    flaw = FLAW_NONE;
                else if (pick < 62)
                    flaw = FLAW_LRC;
                else if (pick < 67)
                    flaw = FLAW_BAD_CHAR;
                else if (pick < 71)
                    flaw = FLAW_ODD;
                else if (pick < 75)
                    flaw = FLAW_RESTART;
                else if (pick < 79)
                    flaw = FLAW_BAD_TERM;
                else if (pick < 83)
                    flaw = FLAW_NO_CR;
                else
                    flaw = FLAW_NONE;
                queue_frame(pick < 84 ? $urandom_range(0, 12) : $urandom_range(118, 130),
                            flaw);
            end
            else
                queue_noise($urandom_range(1, 6));
        end
        tail_start = char_queue.size() - TAIL_CHARS;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("ascii_hex_frame_receiver_lrc_top_tb: PASS");
        else
            $display("ascii_hex_frame_receiver_lrc_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #(LIMIT_TIME);
        $display("ascii_hex_frame_receiver_lrc_top_tb: FAIL");
        $finish;
    end

endmodule

/* ascii_hex_frame_receiver_lrc_top.f */
+incdir+src
src/ahfr_pkg.sv
src/ahfr_in_reg.sv
src/ahfr_core.sv
src/ahfr_out_reg.sv
src/ascii_hex_frame_receiver_lrc_top.sv
bench/ascii_hex_frame_receiver_lrc_top_tb.sv
